// ===== rtl/core/tdlm_pkg.sv =====
// Shared constants, codes and types for the table-driven longest-match DFA.
package tdlm_pkg;

	// Parameter defaults
	localparam int STATE_COUNT_DEF = 128;
	localparam int SYMBOL_BITS_DEF = 7;
	localparam int LENGTH_BITS_DEF = 16;

	// Fixed field widths
	localparam int FIELD_W    = 7;
	localparam int FUNC_W     = 2;
	localparam int OUT_LEN_W  = 16;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Request function codes
	localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	// Match mode register values
	localparam logic MODE_GREEDY = 1'b0;
	localparam logic MODE_WHOLE  = 1'b1;

	// Register index (word address)
	localparam logic [CFG_ADDR_W-3:0] REG_MATCH_MODE = 1'b0;

	// Table port control
	typedef struct packed {
		logic wr;
		logic rd;
	} tbl_ctl_t;

endpackage

// ===== rtl/core/table_dfa_longest_match.sv =====
// Top level of the table-driven longest-match DFA scanner.
//
// Requests arrive on the s_* stream: s_tuser carries the function (scan a
// symbol, write a table cell, remove a table cell), s_tlast marks the final
// symbol of a string, s_tdata carries symbol, row, target state and accept bit.
// Results leave on the m_* stream: match flag and saturated length. A scan
// step gives at most one result; table writes and removals give none.
// The match_mode register (APB, address 0) selects greedy longest prefix (0)
// or whole-string acceptance (1); write it only while the block is idle.
// Throughput: one request per cycle unless the table clear runs or a result
// waits on a stalled output. Each scan does one table read whose address
// comes from the state left by the previous step, so the loop is one memory
// read plus the step logic. A result reaches m_tdata via the table read and
// request register, taken together, then the result register.
// After reset the table is swept empty, one cell per cycle:
// 2**(clog2(STATE_COUNT)+SYMBOL_BITS) cells, 16384 at the defaults; s_tready
// stays low meanwhile while APB writes are taken. When m_tready is low the
// result register holds, one more request can sit in the step stage, and
// s_tready drops only if that request would also produce a result.
module table_dfa_longest_match #(
	parameter int STATE_COUNT = tdlm_pkg::STATE_COUNT_DEF,
	parameter int SYMBOL_BITS = tdlm_pkg::SYMBOL_BITS_DEF,
	parameter int LENGTH_BITS = tdlm_pkg::LENGTH_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// symbol[6:0], table_state[13:7], next_state[20:14], accepting[21], zero[23:22]
	input  logic [tdlm_pkg::IN_DATA_W-1:0]       s_tdata,
	// func[1:0]
	input  logic [tdlm_pkg::FUNC_W-1:0]          s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// match_found[0], match_length[16:1], zero[23:17]
	output logic [tdlm_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tdlm_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [tdlm_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [tdlm_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	localparam int ROW_W  = $clog2(STATE_COUNT);
	localparam int CELL_W = ROW_W + 2;
	localparam int ADDR_W = ROW_W + SYMBOL_BITS;

	logic                match_mode;
	tdlm_pkg::tbl_ctl_t  tbl_ctl;
	logic [ADDR_W-1:0]   tbl_addr;
	logic [CELL_W-1:0]   tbl_wdata;
	logic [CELL_W-1:0]   tbl_rdata;
	logic                busy;

	tdlm_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.match_mode (match_mode)
	);

	tdlm_table #(
		.ADDR_W (ADDR_W),
		.CELL_W (CELL_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tbl_ctl),
		.addr   (tbl_addr),
		.wdata  (tbl_wdata),
		.rdata  (tbl_rdata),
		.busy   (busy)
	);

	tdlm_scan #(
		.STATE_COUNT (STATE_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.ROW_W       (ROW_W),
		.CELL_W      (CELL_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.match_mode (match_mode),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.tbl_ctl    (tbl_ctl),
		.tbl_addr   (tbl_addr),
		.tbl_wdata  (tbl_wdata),
		.tbl_rdata  (tbl_rdata),
		.busy       (busy)
	);

endmodule

// ===== rtl/core/tdlm_cfg.sv =====
// Configuration register block with APB-style access.
module tdlm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tdlm_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [tdlm_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [tdlm_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic                                match_mode
);

	logic match_mode_q;
	logic sel_mode;
	logic wr_en;

	assign pready   = 1'b1;
	assign sel_mode = (paddr[tdlm_pkg::CFG_ADDR_W-1:2] == tdlm_pkg::REG_MATCH_MODE);
	assign wr_en    = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_mode_q <= tdlm_pkg::MODE_GREEDY;
		end else if (wr_en && sel_mode) begin
			match_mode_q <= pwdata[0];
		end
	end

	assign prdata     = sel_mode ? {{(tdlm_pkg::CFG_DATA_W-1){1'b0}}, match_mode_q} : '0;
	assign match_mode = match_mode_q;

endmodule

// ===== rtl/core/tdlm_table.sv =====
// Transition table memory with a clearing sweep after reset.
module tdlm_table #(
	parameter int ADDR_W = 14,
	parameter int CELL_W = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tdlm_pkg::tbl_ctl_t  ctl,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [CELL_W-1:0]   wdata,
	output logic [CELL_W-1:0]   rdata,
	output logic                busy
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// empty cell = valid bit low
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// ===== rtl/core/tdlm_scan.sv =====
// Request decode, table access, scan step stage and result register.
module tdlm_scan #(
	parameter int STATE_COUNT = tdlm_pkg::STATE_COUNT_DEF,
	parameter int SYMBOL_BITS = tdlm_pkg::SYMBOL_BITS_DEF,
	parameter int LENGTH_BITS = tdlm_pkg::LENGTH_BITS_DEF,
	parameter int ROW_W       = $clog2(STATE_COUNT),
	parameter int CELL_W      = ROW_W + 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 match_mode,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tdlm_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [tdlm_pkg::FUNC_W-1:0]          s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tdlm_pkg::OUT_DATA_W-1:0]      m_tdata,
	output tdlm_pkg::tbl_ctl_t                   tbl_ctl,
	output logic [ROW_W+SYMBOL_BITS-1:0]         tbl_addr,
	output logic [CELL_W-1:0]                    tbl_wdata,
	input  logic [CELL_W-1:0]                    tbl_rdata,
	input  logic                                 busy
);

	localparam int FW      = tdlm_pkg::FIELD_W;
	localparam int SYM_USE = (SYMBOL_BITS < FW) ? SYMBOL_BITS : FW;
	localparam int LW      = (LENGTH_BITS > tdlm_pkg::OUT_LEN_W) ? LENGTH_BITS
	                                                              : tdlm_pkg::OUT_LEN_W;
	localparam logic [FW:0]    SC_F = (FW+1)'(STATE_COUNT);
	localparam logic [ROW_W:0] SC_R = (ROW_W+1)'(STATE_COUNT);

	// request fields
	logic [tdlm_pkg::FUNC_W-1:0] in_func;
	logic [FW-1:0]               in_symbol;
	logic [FW-1:0]               in_table_state;
	logic [FW-1:0]               in_next_state;
	logic                        in_accepting;
	logic [SYMBOL_BITS-1:0]      sym;
	logic                        ts_ok;
	logic                        ns_ok;
	logic                        s_acc;

	// stage 1
	logic                        valid_s1;
	logic                        scan_s1;
	logic                        last_s1;
	logic                        s1_go;

	// scan state
	logic [ROW_W-1:0]            state_q;
	logic [LENGTH_BITS-1:0]      cnt_q;
	logic [LENGTH_BITS-1:0]      best_q;
	logic                        have_q;
	logic                        drain_q;

	logic [ROW_W-1:0]            state_nx;
	logic [LENGTH_BITS-1:0]      cnt_nx;
	logic [LENGTH_BITS-1:0]      best_nx;
	logic                        have_nx;
	logic                        drain_nx;
	logic                        res_valid;
	logic                        res_found;
	logic [LENGTH_BITS-1:0]      res_len;
	logic [LENGTH_BITS-1:0]      cnt_inc;
	logic                        cell_v;
	logic [ROW_W-1:0]            cell_st;
	logic                        cell_acc;
	logic                        g_acc;
	logic [LW-1:0]               len_ext;
	logic [tdlm_pkg::OUT_LEN_W-1:0] len_sat;

	// result register
	logic                        out_valid_q;
	logic                        out_found_q;
	logic [tdlm_pkg::OUT_LEN_W-1:0] out_len_q;
	logic                        out_free;

	assign in_func        = s_tuser;
	assign in_symbol      = s_tdata[FW-1:0];
	assign in_table_state = s_tdata[2*FW-1:FW];
	assign in_next_state  = s_tdata[3*FW-1:2*FW];
	assign in_accepting   = s_tdata[3*FW];

	assign sym   = SYMBOL_BITS'(in_symbol[SYM_USE-1:0]);
	assign ts_ok = ({1'b0, in_table_state} < SC_F);
	assign ns_ok = ({1'b0, in_next_state} < SC_F);

	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!res_valid || out_free);
	assign s_tready = !busy && (!valid_s1 || s1_go);
	assign s_acc    = s_tvalid && s_tready;

	// table port: scans read at the row the current step leaves behind
	always_comb begin
		tbl_ctl.rd = s_acc && (in_func == tdlm_pkg::FUNC_SCAN);
		tbl_ctl.wr = s_acc && (((in_func == tdlm_pkg::FUNC_WRITE) && ts_ok && ns_ok) ||
		                       ((in_func == tdlm_pkg::FUNC_REMOVE) && ts_ok));
		tbl_wdata  = (in_func == tdlm_pkg::FUNC_WRITE)
		           ? {1'b1, in_next_state[ROW_W-1:0], in_accepting} : '0;
		if (in_func == tdlm_pkg::FUNC_SCAN) begin
			tbl_addr = {state_nx, sym};
		end else begin
			tbl_addr = {in_table_state[ROW_W-1:0], sym};
		end
	end

	assign cell_v   = tbl_rdata[CELL_W-1];
	assign cell_st  = tbl_rdata[ROW_W:1];
	assign cell_acc = tbl_rdata[0];
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign g_acc    = cell_v && cell_acc;

	always_comb begin
		state_nx  = state_q;
		cnt_nx    = cnt_q;
		best_nx   = best_q;
		have_nx   = have_q;
		drain_nx  = drain_q;
		res_valid = 1'b0;
		res_found = 1'b0;
		res_len   = '0;
		if (valid_s1 && scan_s1) begin
			if (drain_q) begin
				if (last_s1) begin
					drain_nx = 1'b0;
					state_nx = '0;
					cnt_nx   = '0;
					best_nx  = '0;
					have_nx  = 1'b0;
				end
			end else begin
				// any result resets the scan; drain the rest of the string
				// when it came before the last symbol
				state_nx = '0;
				cnt_nx   = '0;
				best_nx  = '0;
				have_nx  = 1'b0;
				drain_nx = 1'b0;
				if (match_mode == tdlm_pkg::MODE_GREEDY) begin
					if ((state_q == '0) && have_q) begin
						res_valid = 1'b1;
						res_found = 1'b1;
						res_len   = best_q;
						drain_nx  = !last_s1;
					end else if (last_s1) begin
						res_valid = 1'b1;
						res_found = have_q || g_acc;
						res_len   = g_acc ? cnt_inc : (have_q ? best_q : '0);
					end else begin
						state_nx = cell_v ? cell_st : '0;
						cnt_nx   = cnt_inc;
						best_nx  = g_acc ? cnt_inc : best_q;
						have_nx  = have_q || g_acc;
					end
				end else begin
					if (!cell_v) begin
						res_valid = 1'b1;
						drain_nx  = !last_s1;
					end else if (last_s1) begin
						res_valid = 1'b1;
						res_found = cell_acc;
						res_len   = cell_acc ? cnt_inc : '0;
					end else begin
						// greedy match record carries through for a later mode change
						state_nx = cell_st;
						cnt_nx   = cnt_inc;
						best_nx  = best_q;
						have_nx  = have_q;
					end
				end
			end
		end
	end

	assign len_ext = LW'(res_len);
	assign len_sat = (len_ext > LW'({tdlm_pkg::OUT_LEN_W{1'b1}}))
	               ? {tdlm_pkg::OUT_LEN_W{1'b1}} : len_ext[tdlm_pkg::OUT_LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			cnt_q       <= '0;
			best_q      <= '0;
			have_q      <= 1'b0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				state_q <= state_nx;
				cnt_q   <= cnt_nx;
				best_q  <= best_nx;
				have_q  <= have_nx;
				drain_q <= drain_nx;
			end
			if (s1_go && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			scan_s1 <= (in_func == tdlm_pkg::FUNC_SCAN);
			last_s1 <= s_tlast;
		end
		if (s1_go && res_valid) begin
			out_found_q <= res_found;
			out_len_q   <= len_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(tdlm_pkg::OUT_DATA_W-tdlm_pkg::OUT_LEN_W-1){1'b0}},
	                   out_len_q, out_found_q};

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("request taken during table clear");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, state_q} < SC_R) else $error("scan state out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid && out_valid_q && !m_tready |=> valid_s1)
		else $error("pending result dropped under stall");

	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && scan_s1 && drain_q |-> !res_valid)
		else $error("result while draining");

	a_result_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && res_valid |=> (cnt_q == '0) && !have_q)
		else $error("scan state not cleared after result");

endmodule
